>>> rtl/rational_accumulator_unit_core_macros.svh
// Assertion macros shared by the rational accumulator RTL.
`ifndef RATIONAL_ACCUMULATOR_UNIT_CORE_MACROS_SVH
`define RATIONAL_ACCUMULATOR_UNIT_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RAU_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RAU_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

>>> rtl/rau_pkg.sv
// Package for the rational accumulator: widths, opcodes and sequencer states.
package rau_pkg;
  localparam int unsigned NUM_BITS_DEF = 32;
  localparam int unsigned DEN_BITS_DEF = 16;
  localparam int unsigned OP_BITS      = 3;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_ADD     = 3'd1,
    OP_SUB     = 3'd2,
    OP_MUL     = 3'd3,
    OP_CMP     = 3'd4,
    OP_SET_NUM = 3'd5,
    OP_SET_DEN = 3'd6,
    OP_NONE    = 3'd7
  } rau_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_GCD,
    ST_DIV2,
    ST_DIV3,
    ST_DONE
  } rau_state_t;
endpackage

>>> rtl/rational_accumulator_unit_core.sv
// Rational accumulator: one held fraction, exact arithmetic, gcd reduction.
// Steps per item: DIV1 (magnitude mod denominator), GCD (k Euclid steps), DIV2,
// DIV3, DONE, with MW = 64 at default widths. Zero denominator: DIV1, DIV3, DONE;
// 0/0: DIV1, DONE; compare or spare code: DONE. Each divide uses the one bit-serial
// divider. One item at a time; in_stall is high while an item is worked or waits.
// Reset (synchronous, rst_n low): held value 0/0, sequencer idle, no result.
`include "rational_accumulator_unit_core_macros.svh"
module rational_accumulator_unit_core import rau_pkg::*; #(
  parameter int unsigned NUM_BITS = NUM_BITS_DEF,
  parameter int unsigned DEN_BITS = DEN_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [OP_BITS-1:0]         in_opcode,
  input  logic signed [NUM_BITS-1:0] in_operand_numerator,
  input  logic [DEN_BITS-1:0]        in_operand_denominator,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [NUM_BITS-1:0] out_result_numerator,
  output logic [DEN_BITS-1:0]        out_result_denominator,
  output logic                       out_is_less,
  output logic                       out_is_equal,
  output logic                       out_is_greater,
  output logic                       out_overflow,
  output logic                       out_zero_error
);
  // magnitude of an exact numerator: the wider of a product of two numerator
  // magnitudes and a magnitude times a denominator plus one carry bit for sums
  localparam int unsigned MW = (2 * NUM_BITS > NUM_BITS + DEN_BITS + 1) ?
                               2 * NUM_BITS : NUM_BITS + DEN_BITS + 1;
  localparam int unsigned DW = 2 * DEN_BITS;   // exact denominator width

  rau_state_t state_r, state_nxt;

  logic [NUM_BITS-1:0] held_num_r, held_num_nxt;
  logic [DEN_BITS-1:0] held_den_r, held_den_nxt;

  // working fraction
  logic          wneg_r, wneg_nxt;
  logic [MW-1:0] wmag_r, wmag_nxt;
  logic [DW-1:0] wden_r, wden_nxt;
  // gcd operands
  logic [DW-1:0] ga_r, ga_nxt, gb_r, gb_nxt;
  // result flags
  logic lt_r, lt_nxt, eq_r, eq_nxt, gt_r, gt_nxt, ovf_r, ovf_nxt, zerr_r, zerr_nxt;
  logic out_valid_r, out_valid_nxt;

  // divider port
  logic          dv_start, dv_busy, dv_done;
  logic [MW-1:0] dv_dividend, dv_q;
  logic [DW-1:0] dv_divisor, dv_rem;

  rau_divider #(.NW(MW), .DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_dividend),
    .divisor(dv_divisor), .busy(dv_busy), .done(dv_done),
    .quotient(dv_q), .remainder(dv_rem)
  );

  // operand decode: sign and magnitude of both numerators
  logic                hneg, oneg;
  logic [NUM_BITS-1:0] hmag, omag;
  assign hneg = held_num_r[NUM_BITS-1];
  assign oneg = in_operand_numerator[NUM_BITS-1];
  assign hmag = hneg ? NUM_BITS'(-held_num_r) : held_num_r;
  assign omag = oneg ? NUM_BITS'(-in_operand_numerator)
                     : NUM_BITS'(in_operand_numerator);

  // cross terms, one multiplier each; fine at default widths
  logic [MW-1:0] t1, t2, tm;
  logic          t1n, t2n;
  assign t1  = MW'(hmag) * MW'(in_operand_denominator);
  assign t2  = MW'(omag) * MW'(held_den_r);
  assign t1n = hneg && (t1 != '0);
  assign t2n = oneg && (t2 != '0);
  assign tm  = MW'(hmag) * MW'(omag);

  // signed sum of t1 and (+/-)t2
  function automatic logic [MW:0] sgn_add(input logic an, input logic [MW-1:0] am,
                                         input logic bn, input logic [MW-1:0] bm);
    logic          rn;
    logic [MW-1:0] rm;
    begin
      if (an == bn) begin
        rn = an; rm = am + bm;
      end else if (am >= bm) begin
        rn = an; rm = am - bm;
      end else begin
        rn = bn; rm = bm - am;
      end
      if (rm == '0) rn = 1'b0;
      sgn_add = {rn, rm};
    end
  endfunction

  logic [MW:0]   sum_s, diff_s;
  logic [DW-1:0] den_prod;
  assign sum_s    = sgn_add(t1n, t1, t2n, t2);
  assign diff_s   = sgn_add(t1n, t1, (t2 != '0) && !t2n, t2);
  assign den_prod = DW'(held_den_r) * DW'(in_operand_denominator);

  logic in_xfer, out_xfer;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  // overflow limit and wrapped store, shared by the final step
  logic [MW-1:0] lim;
  logic [MW-1:0] fin_mag;
  logic [DW-1:0] fin_den;

  always_comb begin
    state_nxt     = state_r;
    held_num_nxt  = held_num_r;
    held_den_nxt  = held_den_r;
    wneg_nxt      = wneg_r;
    wmag_nxt      = wmag_r;
    wden_nxt      = wden_r;
    ga_nxt        = ga_r;
    gb_nxt        = gb_r;
    lt_nxt        = lt_r;
    eq_nxt        = eq_r;
    gt_nxt        = gt_r;
    ovf_nxt       = ovf_r;
    zerr_nxt      = zerr_r;
    out_valid_nxt = out_valid_r && !out_xfer;
    dv_start      = 1'b0;
    dv_dividend   = wmag_r;
    dv_divisor    = wden_r;
    fin_mag       = wmag_r;
    fin_den       = wden_r;
    lim           = wneg_r ? (MW'(1) << (NUM_BITS - 1))
                           : ((MW'(1) << (NUM_BITS - 1)) - MW'(1));
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          lt_nxt   = diff_s[MW] && (diff_s[MW-1:0] != '0);
          eq_nxt   = diff_s[MW-1:0] == '0;
          gt_nxt   = !diff_s[MW] && (diff_s[MW-1:0] != '0);
          ovf_nxt  = 1'b0;
          zerr_nxt = 1'b0;
          state_nxt = ST_DIV1;
          unique case (rau_op_t'(in_opcode))
            OP_LOAD: begin
              wneg_nxt = oneg; wmag_nxt = MW'(omag);
              wden_nxt = DW'(in_operand_denominator);
            end
            OP_ADD: begin
              wneg_nxt = sum_s[MW]; wmag_nxt = sum_s[MW-1:0]; wden_nxt = den_prod;
            end
            OP_SUB: begin
              wneg_nxt = diff_s[MW]; wmag_nxt = diff_s[MW-1:0]; wden_nxt = den_prod;
            end
            OP_MUL: begin
              wneg_nxt = hneg != oneg; wmag_nxt = tm; wden_nxt = den_prod;
            end
            OP_SET_NUM: begin
              wneg_nxt = oneg; wmag_nxt = MW'(omag); wden_nxt = DW'(held_den_r);
            end
            OP_SET_DEN: begin
              wneg_nxt = hneg; wmag_nxt = MW'(hmag);
              wden_nxt = DW'(in_operand_denominator);
            end
            OP_CMP, OP_NONE: begin
              state_nxt = ST_DONE;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_DIV1: begin
        if (wmag_r == '0) wneg_nxt = 1'b0;
        if (wden_r == '0) begin
          if (wmag_r == '0) begin
            zerr_nxt = 1'b1;
            held_num_nxt = '0;
            held_den_nxt = '0;
            state_nxt = ST_DONE;
          end else begin
            wmag_nxt = MW'(1);
            state_nxt = ST_DIV3;
            ga_nxt = DW'(1);
          end
        end else if (!dv_busy && !dv_done) begin
          dv_start = 1'b1;
        end else if (dv_done) begin
          ga_nxt = wden_r;
          gb_nxt = dv_rem;
          state_nxt = ST_GCD;
        end
      end
      ST_GCD: begin
        // one Euclid step per divider pass
        dv_dividend = MW'(ga_r);
        dv_divisor  = gb_r;
        if (gb_r == '0) begin
          state_nxt = ST_DIV2;
        end else if (!dv_busy && !dv_done) begin
          dv_start = 1'b1;
        end else if (dv_done) begin
          ga_nxt = gb_r;
          gb_nxt = dv_rem;
        end
      end
      ST_DIV2: begin
        dv_dividend = wmag_r;
        dv_divisor  = ga_r;
        if (!dv_busy && !dv_done) begin
          dv_start = 1'b1;
        end else if (dv_done) begin
          wmag_nxt  = dv_q;
          state_nxt = ST_DIV3;
        end
      end
      ST_DIV3: begin
        dv_dividend = MW'(wden_r);
        dv_divisor  = ga_r;
        if (!dv_busy && !dv_done) begin
          dv_start = 1'b1;
        end else if (dv_done) begin
          fin_den = dv_q[DW-1:0];
          ovf_nxt = (fin_mag > lim) || (fin_den > DW'({DEN_BITS{1'b1}}));
          held_num_nxt = wneg_r ? NUM_BITS'(-fin_mag) : NUM_BITS'(fin_mag);
          held_den_nxt = fin_den[DEN_BITS-1:0];
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    wneg_r <= wneg_nxt;
    wmag_r <= wmag_nxt;
    wden_r <= wden_nxt;
    ga_r   <= ga_nxt;
    gb_r   <= gb_nxt;
    lt_r   <= lt_nxt;
    eq_r   <= eq_nxt;
    gt_r   <= gt_nxt;
    ovf_r  <= ovf_nxt;
    zerr_r <= zerr_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_num_r  <= '0;
      held_den_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_num_r  <= held_num_nxt;
      held_den_r  <= held_den_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // one item in flight; the result fields are the held registers, so a waiting
  // result holds off the next transfer
  assign in_stall               = (state_r != ST_IDLE) || out_valid_r;
  assign out_valid              = out_valid_r;
  assign out_result_numerator   = held_num_r;
  assign out_result_denominator = held_den_r;
  assign out_is_less            = lt_r;
  assign out_is_equal           = eq_r;
  assign out_is_greater         = gt_r;
  assign out_overflow           = ovf_r;
  assign out_zero_error         = zerr_r;

  `RAU_ASSERT_IMP(a_flags_onehot, clk, rst_n, out_valid_r, $onehot({lt_r, eq_r, gt_r}))
  `RAU_ASSERT_IMP(a_zerr_clean, clk, rst_n, out_valid_r && zerr_r,
                  held_num_r == '0 && held_den_r == '0 && !ovf_r)
  `RAU_ASSERT_NXT(a_accept_busy, clk, rst_n, in_xfer, state_r != ST_IDLE)
  `RAU_ASSERT_IMP(a_div_idle, clk, rst_n, state_r == ST_IDLE, !dv_busy)
endmodule

>>> rtl/rau_divider.sv
// Shared restoring divider: one quotient bit per cycle.
module rau_divider import rau_pkg::*; #(
  parameter int unsigned NW = 96,
  parameter int unsigned DW = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder
);
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] r_r, r_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [DW:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (start) begin
      q_nxt    = dividend;
      r_nxt    = '0;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {r_r, q_r[NW-1]};
      q_nxt = {q_r[NW-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial    = trial - {1'b0, divisor};
        q_nxt[0] = 1'b1;
      end
      r_nxt   = trial[DW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    r_r   <= r_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = r_r;
endmodule
